### rtl/lrtm_pkg.sv
// Package: shared types, constants and register codes for the laser range trimmed-mean filter.
package lrtm_pkg;

    // Configuration of the sampling scheme
    localparam int CHANNELS = 5;
    localparam int SAMPLES  = 7;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int DIST_W   = 10;
    localparam int BAND_W   = 8;
    localparam int SUM_W    = 13;
    localparam int CNT_W    = 3;
    localparam int CHAN_W   = 3;
    localparam int HGT_W    = 12;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Frame markers
    localparam logic [BYTE_W-1:0] HEAD_OK = 8'h75;
    localparam logic [BYTE_W-1:0] TAIL_OK = 8'h07;

    // Divide by the number of kept samples as a reciprocal multiply
    localparam int DIVISOR     = SAMPLES - 2;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** RECIP_SHIFT) + DIVISOR - 1) / DIVISOR);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_DEADBAND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT     = 3'd4;

    // Register reset values
    localparam logic [DIST_W-1:0] RST_SENSOR_LIMIT    = 10'd1000;
    localparam logic [DIST_W-1:0] RST_MOUNT_OFFSET    = 10'd100;
    localparam logic [DIST_W-1:0] RST_LEVEL_LIMIT     = 10'd500;
    localparam logic [BAND_W-1:0] RST_CHANGE_DEADBAND = 8'd2;
    localparam logic [DIST_W-1:0] RST_BASE_HEIGHT     = 10'd350;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_head;
        logic [BYTE_W-1:0] range_high;
        logic [BYTE_W-1:0] range_low;
        logic [BYTE_W-1:0] frame_tail;
    } t_in;

    typedef struct packed {
        logic [CHAN_W-1:0]       channel;
        logic [DIST_W-1:0]       level;
        logic [DIST_W-1:0]       held_level;
        logic                    level_changed;
        logic signed [HGT_W-1:0] object_height;
        logic                    round_done;
    } t_out;

    typedef struct packed {
        logic [DIST_W-1:0] sensor_limit;
        logic [DIST_W-1:0] mount_offset;
        logic [DIST_W-1:0] level_limit;
        logic [BAND_W-1:0] change_deadband;
        logic [DIST_W-1:0] base_height;
    } t_cfg;

    // One finished sample group, handed from the accumulator to the level stages
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [DIST_W-1:0] max;
        logic [DIST_W-1:0] min;
        logic [CHAN_W-1:0] channel;
        logic              done;
    } t_grp;

endpackage

### rtl/lrtm_accum.sv
// Sample accumulator: frame check, distance clamp, running sum, min and max per group.
module lrtm_accum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lrtm_pkg::t_in   i_data,
    input  logic            i_hold,
    input  lrtm_pkg::t_cfg  i_cfg,
    output logic            o_stall,
    output logic            o_grp_valid,
    output lrtm_pkg::t_grp  o_grp
);
    import lrtm_pkg::*;

    logic [CNT_W-1:0]  r_cnt;
    logic [CHAN_W-1:0] r_chan;
    logic [SUM_W-1:0]  r_sum;
    logic [DIST_W-1:0] r_max;
    logic [DIST_W-1:0] r_min;
    logic [DIST_W-1:0] r_last;

    logic              accept;
    logic              good;
    logic [15:0]       d_sel;
    logic [DIST_W-1:0] d;
    logic [SUM_W-1:0]  n_sum;
    logic [DIST_W-1:0] n_max;
    logic [DIST_W-1:0] n_min;
    logic              close;
    logic              last_chan;

    assign o_stall = i_hold;
    assign accept  = i_valid & ~i_hold;

    // Pick the frame distance or reuse the last one, then clamp
    always_comb begin
        good  = (i_data.frame_head == HEAD_OK) && (i_data.frame_tail == TAIL_OK);
        d_sel = good ? {i_data.range_high, i_data.range_low} : {6'd0, r_last};
        d     = (d_sel > {6'd0, i_cfg.sensor_limit}) ? i_cfg.sensor_limit : d_sel[DIST_W-1:0];
    end

    // Running statistics including this beat
    always_comb begin
        n_sum     = r_sum + SUM_W'(d);
        n_max     = (d > r_max) ? d : r_max;
        n_min     = (d < r_min) ? d : r_min;
        close     = accept && (r_cnt == CNT_W'(SAMPLES - 1));
        last_chan = (r_chan == CHAN_W'(CHANNELS - 1));
    end

    assign o_grp_valid   = close;
    assign o_grp.sum     = n_sum;
    assign o_grp.max     = n_max;
    assign o_grp.min     = n_min;
    assign o_grp.channel = r_chan;
    assign o_grp.done    = last_chan;

    // Advance the group state on every accepted beat, restart on close
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_chan <= '0;
            r_sum  <= '0;
            r_max  <= '0;
            r_min  <= '1;
            r_last <= '0;
        end else if (accept) begin
            r_last <= d;
            if (close) begin
                r_cnt  <= '0;
                r_sum  <= '0;
                r_max  <= '0;
                r_min  <= '1;
                r_chan <= last_chan ? '0 : r_chan + 1'b1;
            end else begin
                r_cnt  <= r_cnt + 1'b1;
                r_sum  <= n_sum;
                r_max  <= n_max;
                r_min  <= n_min;
            end
        end
    end

endmodule

### rtl/lrtm_held_ram.sv
// Held-level memory: one entry per channel, registered read, valid bits for reset to zero.
module lrtm_held_ram (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [lrtm_pkg::CH_AW-1:0]   i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [lrtm_pkg::CH_AW-1:0]   i_wr_addr,
    input  logic [lrtm_pkg::DIST_W-1:0]  i_wr_data,
    output logic [lrtm_pkg::DIST_W-1:0]  o_rd_data
);
    import lrtm_pkg::*;

    logic [DIST_W-1:0]   r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_vld;
    logic [DIST_W-1:0]   r_rd;

    // Write the entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Mark written entries; reset makes every entry read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Read with forwarding of a same-cycle write to the same entry
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd <= i_wr_data;
            end else if (r_vld[i_rd_addr]) begin
                r_rd <= r_mem[i_rd_addr];
            end else begin
                r_rd <= '0;
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

### rtl/lrtm_level.sv
// Level pipeline: trimmed mean, offset and clamp, deadband update and output register.
module lrtm_level (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_grp_valid,
    input  lrtm_pkg::t_grp  i_grp,
    input  lrtm_pkg::t_cfg  i_cfg,
    input  logic            i_out_stall,
    output logic            o_hold,
    output logic            o_out_valid,
    output lrtm_pkg::t_out  o_out_data
);
    import lrtm_pkg::*;

    // Stage B: group totals
    logic              r_bv;
    t_grp              r_b;
    // Stage C: scaled product and held level read
    logic              r_cv;
    logic [PROD_W-1:0] r_c_prod;
    logic [CHAN_W-1:0] r_c_chan;
    logic              r_c_done;
    // Output register
    logic              r_ov;
    t_out              r_out;

    logic              b_adv;
    logic              c_adv;
    logic              out_take;
    logic [SUM_W-1:0]  trimmed;
    logic [PROD_W-1:0] n_prod;
    logic [DIST_W-1:0] held_old;
    logic [DIST_W-1:0] mean;
    logic [DIST_W-1:0] level_sub;
    logic [DIST_W-1:0] level;
    logic [DIST_W-1:0] diff;
    logic              changed;
    logic [HGT_W-1:0]  height;

    assign out_take = r_ov & ~i_out_stall;
    assign c_adv    = r_cv & (~r_ov | out_take);
    assign b_adv    = r_bv & (~r_cv | c_adv);
    assign o_hold   = r_bv & ~b_adv;

    // Drop largest and smallest, scale by the reciprocal of the kept count
    always_comb begin
        trimmed = r_b.sum - SUM_W'(r_b.min) - SUM_W'(r_b.max);
        n_prod  = PROD_W'(trimmed) * PROD_W'(RECIP);
    end

    // Offset, clamp, deadband and height
    always_comb begin
        mean      = r_c_prod[RECIP_SHIFT +: DIST_W];
        level_sub = (mean > i_cfg.mount_offset) ? mean - i_cfg.mount_offset : '0;
        level     = (level_sub > i_cfg.level_limit) ? i_cfg.level_limit : level_sub;
        diff      = (held_old > level) ? held_old - level : level - held_old;
        changed   = diff > {2'd0, i_cfg.change_deadband};
        height    = {2'd0, i_cfg.base_height}
                  - ({2'd0, level} + {2'd0, i_cfg.mount_offset});
    end

    lrtm_held_ram u_held (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (b_adv),
        .i_rd_addr (r_b.channel[CH_AW-1:0]),
        .i_wr_en   (c_adv & changed),
        .i_wr_addr (r_c_chan[CH_AW-1:0]),
        .i_wr_data (level),
        .o_rd_data (held_old)
    );

    // Advance stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
            r_cv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_grp_valid) begin
                r_bv <= 1'b1;
            end else if (b_adv) begin
                r_bv <= 1'b0;
            end
            if (b_adv) begin
                r_cv <= 1'b1;
            end else if (c_adv) begin
                r_cv <= 1'b0;
            end
            if (c_adv) begin
                r_ov <= 1'b1;
            end else if (out_take) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Load stage payloads
    always_ff @(posedge i_clk) begin
        if (i_grp_valid) begin
            r_b <= i_grp;
        end
        if (b_adv) begin
            r_c_prod <= n_prod;
            r_c_chan <= r_b.channel;
            r_c_done <= r_b.done;
        end
        if (c_adv) begin
            r_out.channel       <= r_c_chan;
            r_out.level         <= level;
            r_out.held_level    <= changed ? level : held_old;
            r_out.level_changed <= changed;
            r_out.object_height <= $signed(height);
            r_out.round_done    <= r_c_done;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

### rtl/laser_range_trimmed_mean.sv
// Top level: configuration registers, sample accumulator and level pipeline.
// Throughput: one sample beat per cycle while o_in_stall is low; one result per completed channel group.
// A group's result passes stage B, stage C and the output register; a result stall can hold any of them.
// The held-level memory read and its deadband write-back close in stage C.
// Reset (synchronous, active low) restores register defaults and zeroes all held levels
// at once; the block accepts beats in the first cycle after reset.
module laser_range_trimmed_mean (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  lrtm_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output lrtm_pkg::t_out                    o_out_data,
    input  logic                              i_cfg_we,
    input  logic [lrtm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lrtm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lrtm_pkg::*;

    t_cfg r_cfg;
    logic hold;
    logic grp_valid;
    t_grp grp;

    // Write configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_limit    <= RST_SENSOR_LIMIT;
            r_cfg.mount_offset    <= RST_MOUNT_OFFSET;
            r_cfg.level_limit     <= RST_LEVEL_LIMIT;
            r_cfg.change_deadband <= RST_CHANGE_DEADBAND;
            r_cfg.base_height     <= RST_BASE_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SENSOR_LIMIT: begin
                    r_cfg.sensor_limit <= i_cfg_data[DIST_W-1:0];
                end
                CFG_MOUNT_OFFSET: begin
                    r_cfg.mount_offset <= i_cfg_data[DIST_W-1:0];
                end
                CFG_LEVEL_LIMIT: begin
                    r_cfg.level_limit <= i_cfg_data[DIST_W-1:0];
                end
                CFG_CHANGE_DEADBAND: begin
                    r_cfg.change_deadband <= i_cfg_data[BAND_W-1:0];
                end
                CFG_BASE_HEIGHT: begin
                    r_cfg.base_height <= i_cfg_data[DIST_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    lrtm_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_data      (i_in_data),
        .i_hold      (hold),
        .i_cfg       (r_cfg),
        .o_stall     (o_in_stall),
        .o_grp_valid (grp_valid),
        .o_grp       (grp)
    );

    lrtm_level u_level (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (grp_valid),
        .i_grp       (grp),
        .i_cfg       (r_cfg),
        .i_out_stall (i_out_stall),
        .o_hold      (hold),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### tb/laser_range_trimmed_mean_checker.sv
// Checker for the laser range trimmed-mean filter: level prediction and result comparison.
module laser_range_trimmed_mean_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  lrtm_pkg::t_in                   i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  lrtm_pkg::t_out                  i_out_data,
    input  logic                            i_cfg_we,
    input  logic [lrtm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lrtm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lrtm_pkg::*;

    localparam int SHOWN_MAX = 10;

    // Shadow registers and filter state
    t_cfg              regs;
    logic [CNT_W-1:0]  samples_seen;
    logic [CHAN_W-1:0] chan_now;
    logic [SUM_W-1:0]  group_sum;
    logic [DIST_W-1:0] group_max;
    logic [DIST_W-1:0] group_min;
    logic [DIST_W-1:0] prev_dist;
    logic [DIST_W-1:0] held [CHANNELS];

    // Channel reports still owed by the block, oldest first
    t_out levels_owed [$];
    int   errors = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic flag_error(input string what, input t_out want, input t_out got);
        errors++;
        if (errors <= SHOWN_MAX) begin
            $display("%0t %s: want ch=%0d level=%0d held=%0d chg=%0b height=%0d done=%0b",
                     $realtime, what, want.channel, want.level, want.held_level,
                     want.level_changed, want.object_height, want.round_done);
            $display("%0t %s:  got ch=%0d level=%0d held=%0d chg=%0b height=%0d done=%0b",
                     $realtime, what, got.channel, got.level, got.held_level,
                     got.level_changed, got.object_height, got.round_done);
        end
    endtask

    // Compare one result beat with the oldest owed report
    task automatic match_report(input t_out got);
        t_out want;
        if (levels_owed.size() == 0) begin
            flag_error("unexpected result", '0, got);
            return;
        end
        want = levels_owed.pop_front();
        if (got.channel !== want.channel || got.level !== want.level ||
            got.held_level !== want.held_level || got.level_changed !== want.level_changed ||
            got.object_height !== want.object_height || got.round_done !== want.round_done)
            flag_error("mismatch", want, got);
    endtask

    // Keep only the low bits of a register; drop writes to unused indexes
    task automatic take_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_SENSOR_LIMIT:    regs.sensor_limit    = val[DIST_W-1:0];
            CFG_MOUNT_OFFSET:    regs.mount_offset    = val[DIST_W-1:0];
            CFG_LEVEL_LIMIT:     regs.level_limit     = val[DIST_W-1:0];
            CFG_CHANGE_DEADBAND: regs.change_deadband = val[BAND_W-1:0];
            CFG_BASE_HEIGHT:     regs.base_height     = val[DIST_W-1:0];
            default: ;
        endcase
    endtask

    // Fold one frame into the running group; close the group on its last sample
    task automatic fold_frame(input t_in f);
        logic [15:0] raw;
        int          kept;
        int          mean;
        int          lvl;
        int          old;
        int          gap;
        int          height;
        logic        changed;
        t_out        r;
        raw = 16'(prev_dist);
        if (f.frame_head == HEAD_OK && f.frame_tail == TAIL_OK)
            raw = {f.range_high, f.range_low};
        if (raw > 16'(regs.sensor_limit))
            raw = 16'(regs.sensor_limit);
        prev_dist = raw[DIST_W-1:0];
        group_sum = group_sum + SUM_W'(prev_dist);
        if (prev_dist > group_max)
            group_max = prev_dist;
        if (prev_dist < group_min)
            group_min = prev_dist;
        samples_seen = samples_seen + 1'b1;
        if (int'(samples_seen) < SAMPLES)
            return;

        // Trimmed mean, offset with floor at zero, then the level clamp
        kept = int'(group_sum) - int'(group_min) - int'(group_max);
        mean = kept / DIVISOR;
        lvl  = (mean > int'(regs.mount_offset)) ? mean - int'(regs.mount_offset) : 0;
        if (lvl > int'(regs.level_limit))
            lvl = int'(regs.level_limit);

        // Replace the held level only outside the deadband
        old     = int'(held[chan_now]);
        gap     = (old > lvl) ? old - lvl : lvl - old;
        changed = (gap > int'(regs.change_deadband));
        if (changed)
            held[chan_now] = DIST_W'(lvl);

        height = int'(regs.base_height) - (lvl + int'(regs.mount_offset));
        r.channel       = chan_now;
        r.level         = DIST_W'(lvl);
        r.held_level    = held[chan_now];
        r.level_changed = changed;
        r.object_height = HGT_W'(height);
        r.round_done    = (int'(chan_now) == CHANNELS - 1);
        levels_owed.push_back(r);

        chan_now     = r.round_done ? '0 : chan_now + 1'b1;
        samples_seen = '0;
        group_sum    = '0;
        group_max    = '0;
        group_min    = '1;
    endtask

    // Watch reset, result beats, register writes and frame beats at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.sensor_limit    = RST_SENSOR_LIMIT;
            regs.mount_offset    = RST_MOUNT_OFFSET;
            regs.level_limit     = RST_LEVEL_LIMIT;
            regs.change_deadband = RST_CHANGE_DEADBAND;
            regs.base_height     = RST_BASE_HEIGHT;
            samples_seen = '0;
            chan_now     = '0;
            group_sum    = '0;
            group_max    = '0;
            group_min    = '1;
            prev_dist    = '0;
            for (int k = 0; k < CHANNELS; k++)
                held[k] = '0;
            levels_owed.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                match_report(i_out_data);
            if (i_cfg_we)
                take_register(i_cfg_idx, i_cfg_data);
            if (i_in_valid && !i_in_stall)
                fold_frame(i_in_data);
        end
        o_errors  <= errors;
        o_pending <= levels_owed.size();
    end

endmodule

### tb/laser_range_trimmed_mean_test.sv
// Testbench top for the laser range trimmed-mean filter: stimulus, register phases and verdict.
module laser_range_trimmed_mean_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lrtm_pkg::*;

    localparam int PHASES     = 8;
    localparam int PHASE_BEATS = 92;
    localparam int CFG_SLOTS  = 2 ** CFG_IDX_W;
    localparam int AIM_TOP    = 1100;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    t_in                   in_data    = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    t_out                  out_data;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    int                    errors;
    int                    pending;

    int   idle_pct   = 0;
    int   stall_pct  = 0;
    int   frames_sent = 0;
    int   aim [CHANNELS];
    t_cfg plans [PHASES];
    int   idle_mix  [4] = '{0, 66, 0, 16};
    int   stall_mix [4] = '{0, 0, 66, 16};

    laser_range_trimmed_mean DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    laser_range_trimmed_mean_checker level_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side at the current rate
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic t_in good_frame(input logic [15:0] d);
        t_in f;
        f.frame_head = HEAD_OK;
        f.range_high = d[15:8];
        f.range_low  = d[7:0];
        f.frame_tail = TAIL_OK;
        return f;
    endfunction

    function automatic t_in broken_frame(input logic [7:0] head, input logic [7:0] tail,
                                         input logic [15:0] d);
        t_in f;
        f = good_frame(d);
        f.frame_head = head;
        f.frame_tail = tail;
        return f;
    endfunction

    function automatic t_cfg random_settings();
        t_cfg s;
        s.sensor_limit    = DIST_W'($urandom);
        s.mount_offset    = DIST_W'($urandom_range(300));
        s.level_limit     = DIST_W'($urandom);
        s.change_deadband = BAND_W'($urandom_range(40));
        s.base_height     = DIST_W'($urandom);
        return s;
    endfunction

    // Mostly well-formed frames that hover around a per-channel distance,
    // so held levels both move and sit inside the deadband
    function automatic t_in next_frame();
        int   slot;
        int   roll;
        int   d;
        t_in  f;
        slot = (frames_sent / SAMPLES) % CHANNELS;
        if (frames_sent % SAMPLES == 0) begin
            if ($urandom_range(3) == 0)
                aim[slot] = $urandom_range(AIM_TOP);
            else
                aim[slot] = aim[slot] + int'($urandom_range(6)) - 3;
            if (aim[slot] < 0)
                aim[slot] = 0;
        end
        roll = $urandom_range(99);
        if (roll < 8)
            return good_frame(16'($urandom));
        if (roll < 18) begin
            f = t_in'($urandom);
            case (roll % 3)
                0: f.frame_head = HEAD_OK;
                1: f.frame_tail = TAIL_OK;
                default: ;
            endcase
            return f;
        end
        d = aim[slot] + int'($urandom_range(12)) - 6;
        if (d < 0)
            d = 0;
        return good_frame(16'(d));
    endfunction

    // Offer one frame beat, idling first at the current rate, and hold it until taken
    task automatic send_frame(input t_in f);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= f;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        frames_sent++;
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write every register slot; the deadband gets stray high bits, unused slots get noise
    task automatic load_settings(input t_cfg s);
        logic [CFG_DATA_W-BAND_W-1:0] spare;
        for (int k = 0; k < CFG_SLOTS; k++) begin
            spare   = ($urandom_range(1) == 0) ? '0 : (CFG_DATA_W-BAND_W)'($urandom);
            cfg_we  <= 1'b1;
            cfg_idx <= k[CFG_IDX_W-1:0];
            case (k[CFG_IDX_W-1:0])
                CFG_SENSOR_LIMIT:    cfg_data <= s.sensor_limit;
                CFG_MOUNT_OFFSET:    cfg_data <= s.mount_offset;
                CFG_LEVEL_LIMIT:     cfg_data <= s.level_limit;
                CFG_CHANGE_DEADBAND: cfg_data <= {spare, s.change_deadband};
                CFG_BASE_HEIGHT:     cfg_data <= s.base_height;
                default:             cfg_data <= CFG_DATA_W'($urandom);
            endcase
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        for (int k = 0; k < CHANNELS; k++)
            aim[k] = $urandom_range(AIM_TOP);
        plans[0] = '{sensor_limit: '0, mount_offset: '0, level_limit: '0,
                     change_deadband: '0, base_height: '0};
        plans[1] = '{sensor_limit: '1, mount_offset: '1, level_limit: '1,
                     change_deadband: '1, base_height: '1};
        plans[2] = '{sensor_limit: RST_SENSOR_LIMIT, mount_offset: RST_MOUNT_OFFSET,
                     level_limit: RST_LEVEL_LIMIT, change_deadband: RST_CHANGE_DEADBAND,
                     base_height: RST_BASE_HEIGHT};
        plans[3] = random_settings();
        plans[4] = '{sensor_limit: '1, mount_offset: '0, level_limit: '1,
                     change_deadband: '0, base_height: '0};
        plans[5] = '{sensor_limit: 10'd500, mount_offset: '1, level_limit: '1,
                     change_deadband: '1, base_height: '1};
        plans[6] = random_settings();
        plans[7] = '{sensor_limit: '1, mount_offset: 10'd50, level_limit: 10'd300,
                     change_deadband: 8'd20, base_height: 10'd600};

        // Hold reset, then release
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under reset settings, three full channel groups.
        // First group: zero, overrange, both markers wrong, only the tail wrong,
        // only the head wrong, then plain values.
        send_frame(good_frame(16'h0000));
        send_frame(good_frame(16'hFFFF));
        send_frame(broken_frame(8'h00, 8'hFF, 16'h00FF));
        send_frame(broken_frame(HEAD_OK, 8'hF8, 16'hFF00));
        send_frame(broken_frame(8'hFF, TAIL_OK, 16'h0001));
        send_frame(good_frame(16'd500));
        send_frame(good_frame(16'd1023));
        // All zero: the offset would take the level below zero, so it floors at zero
        repeat (SAMPLES) send_frame(good_frame(16'h0000));
        // Far above the level clamp, with sensor-limit clamping mixed in
        for (int k = 0; k < SAMPLES; k++)
            send_frame(good_frame((k % 2 == 0) ? 16'd1000 : 16'd2000));

        // Register phases with random frames under each idle and stall mix
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            load_settings(plans[p]);
            idle_pct  = idle_mix[p % 4];
            stall_pct = stall_mix[p % 4];
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (p == 4 && n == PHASE_BEATS / 2)
                    wait_idle();
                send_frame(next_frame());
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
rtl/lrtm_pkg.sv
rtl/lrtm_accum.sv
rtl/lrtm_held_ram.sv
rtl/lrtm_level.sv
rtl/laser_range_trimmed_mean.sv
tb/laser_range_trimmed_mean_checker.sv
tb/laser_range_trimmed_mean_test.sv
